### sv/shpr_pkg.sv
`default_nettype none

package shpr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W = 2;

    // Fletcher modulus
    localparam logic [BYTE_W:0] FLETCHER_MOD = 9'd255;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_NOT_LAST    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SUM     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_OPCODE = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_HIGH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd2;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        byte_t first_sum;
        byte_t second_sum;
    } fletcher_t;

    typedef struct packed {
        byte_t                payload_byte;
        byte_t                byte_pos;
        logic                 last;
        logic [STATUS_W-1:0]  status;
    } result_t;

endpackage

`default_nettype wire

### sv/shpr_if.sv
`default_nettype none

interface shpr_in_if;
    import shpr_pkg::*;

    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface shpr_out_if;
    import shpr_pkg::*;

    logic                valid;
    logic                ready;
    byte_t               payload_byte;
    byte_t               byte_pos;
    logic                last;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output payload_byte, output byte_pos, output last,
                    output status, input ready);
    modport sink   (input valid, input payload_byte, input byte_pos, input last,
                    input status, output ready);
endinterface

interface shpr_cfg_if;
    import shpr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    byte_t                data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/shpr_fletcher.sv
`default_nettype none

// One Fletcher-16 step, both sums mod 255.
module shpr_fletcher (
    input  wire shpr_pkg::fletcher_t sums,
    input  wire shpr_pkg::byte_t     data,
    output shpr_pkg::fletcher_t      sums_next
);
    import shpr_pkg::*;

    logic [BYTE_W:0] raw1;
    logic [BYTE_W:0] raw2;
    logic [BYTE_W:0] mod1;
    logic [BYTE_W:0] mod2;

    // each raw sum stays below 2*255, so one conditional subtract suffices
    always_comb
    begin
        raw1 = {1'b0, sums.first_sum} + {1'b0, data};
        mod1 = (raw1 >= FLETCHER_MOD) ? raw1 - FLETCHER_MOD : raw1;
        raw2 = {1'b0, sums.second_sum} + mod1;
        mod2 = (raw2 >= FLETCHER_MOD) ? raw2 - FLETCHER_MOD : raw2;
        sums_next.first_sum  = mod1[BYTE_W-1:0];
        sums_next.second_sum = mod2[BYTE_W-1:0];
    end

endmodule

`default_nettype wire

### sv/sync_header_packet_receiver.sv
`default_nettype none

// Channel  Dir  Beat contents                             Handshake
// rx       in   rx_byte                                   valid/ready
// tx       out  payload_byte, byte_pos, last, status      valid/ready
// cfg      in   index (0 sync_high, 1 sync_low, 2 max_length), data   valid/ready
//
// One rx beat per cycle while rx.ready is high; payload bytes reach tx registered.
// Header bytes and hunting bytes produce no tx beat.
// Reset (rst_n low, async): hunting, window and sums cleared, sync bytes 0, limit 255.
// tx stalls are absorbed by a two-entry output buffer (output reg plus skid);
// rx.ready drops only while the skid entry is full. cfg is always ready.
module sync_header_packet_receiver (
    input  wire logic   clk,
    input  wire logic   rst_n,
    shpr_in_if.sink     rx,
    shpr_out_if.source  tx,
    shpr_cfg_if.sink    cfg
);
    import shpr_pkg::*;

    // configuration
    byte_t sync_high_reg;
    byte_t sync_low_reg;
    byte_t max_length_reg;

    // framing state
    byte_t     window_older_reg, window_older_next;
    byte_t     window_newer_reg, window_newer_next;
    logic      in_payload_reg, in_payload_next;
    byte_t     bytes_left_reg, bytes_left_next;
    byte_t     position_reg, position_next;
    fletcher_t sums_reg, sums_next;
    logic      opcode_zero_reg, opcode_zero_next;

    // output buffer
    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;
    result_t skid_reg, skid_next;
    logic    skid_valid_reg, skid_valid_next;

    fletcher_t step_sums;
    result_t   result;
    logic      accept;
    logic      produce;
    logic      take;
    logic      header_hit;
    logic      is_last;
    logic      opcode_zero_now;

    assign cfg.ready = 1'b1;
    assign rx.ready  = !skid_valid_reg;
    assign accept    = rx.valid && rx.ready;
    assign produce   = accept && in_payload_reg;
    assign take      = out_valid_reg && tx.ready;

    assign tx.valid        = out_valid_reg;
    assign tx.payload_byte = out_reg.payload_byte;
    assign tx.byte_pos     = out_reg.byte_pos;
    assign tx.last         = out_reg.last;
    assign tx.status       = out_reg.status;

    shpr_fletcher u_fletcher (
        .sums      (sums_reg),
        .data      (rx.rx_byte),
        .sums_next (step_sums)
    );

    // header: window matches ID bytes and length in 1..limit
    assign header_hit = (window_older_reg == sync_high_reg) &&
                        (window_newer_reg == sync_low_reg) &&
                        (rx.rx_byte != '0) &&
                        (rx.rx_byte <= max_length_reg);

    assign is_last         = (bytes_left_reg <= 8'd1);
    assign opcode_zero_now = (position_reg == '0) ? (rx.rx_byte == '0) : opcode_zero_reg;

    always_comb
    begin
        result.payload_byte = rx.rx_byte;
        result.byte_pos     = position_reg;
        result.last         = is_last;
        if (!is_last)
        begin
            result.status = STATUS_NOT_LAST;
        end
        else if (opcode_zero_now)
        begin
            result.status = STATUS_ZERO_OPCODE;
        end
        else if (step_sums != '0)
        begin
            result.status = STATUS_BAD_SUM;
        end
        else
        begin
            result.status = STATUS_OK;
        end
    end

    // framing state update
    always_comb
    begin
        window_older_next = window_older_reg;
        window_newer_next = window_newer_reg;
        in_payload_next   = in_payload_reg;
        bytes_left_next   = bytes_left_reg;
        position_next     = position_reg;
        sums_next         = sums_reg;
        opcode_zero_next  = opcode_zero_reg;
        if (accept)
        begin
            if (!in_payload_reg)
            begin
                if (header_hit)
                begin
                    in_payload_next   = 1'b1;
                    bytes_left_next   = rx.rx_byte;
                    position_next     = '0;
                    sums_next         = '0;
                    opcode_zero_next  = 1'b0;
                    window_older_next = '0;
                    window_newer_next = '0;
                end
                else
                begin
                    window_older_next = window_newer_reg;
                    window_newer_next = rx.rx_byte;
                end
            end
            else if (is_last)
            begin
                // packet done: back to hunting with a clean window
                in_payload_next   = 1'b0;
                window_older_next = '0;
                window_newer_next = '0;
                bytes_left_next   = '0;
                position_next     = '0;
                sums_next         = '0;
                opcode_zero_next  = 1'b0;
            end
            else
            begin
                bytes_left_next  = bytes_left_reg - 8'd1;
                position_next    = position_reg + 8'd1;
                sums_next        = step_sums;
                opcode_zero_next = opcode_zero_now;
            end
        end
    end

    // output buffer: skid only fills while out is stalled
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = result;
                out_valid_next = produce;
            end
        end
        else if (produce)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_high_reg    <= '0;
            sync_low_reg     <= '0;
            max_length_reg   <= 8'd255;
            window_older_reg <= '0;
            window_newer_reg <= '0;
            in_payload_reg   <= 1'b0;
            bytes_left_reg   <= '0;
            position_reg     <= '0;
            sums_reg         <= '0;
            opcode_zero_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_SYNC_HIGH:  sync_high_reg  <= cfg.data;
                    CFG_SYNC_LOW:   sync_low_reg   <= cfg.data;
                    CFG_MAX_LENGTH: max_length_reg <= cfg.data;
                    default:        ;
                endcase
            end
            window_older_reg <= window_older_next;
            window_newer_reg <= window_newer_next;
            in_payload_reg   <= in_payload_next;
            bytes_left_reg   <= bytes_left_next;
            position_reg     <= position_next;
            sums_reg         <= sums_next;
            opcode_zero_reg  <= opcode_zero_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

### verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import shpr_pkg::*;

    // Cycles allowed after the last expected beat before a register write or
    // the end of the run. Header bytes give no beat but still have to land.
    localparam int SETTLE_CYCLES = 4;
    // Cycles with no beat on any channel before the run is declared hung.
    localparam int QUIET_LIMIT   = 4000;

    typedef enum {FRAME_GOOD, FRAME_NOISY_SUM, FRAME_ZERO_OPCODE} frame_kind_t;

    // ------------------------------------------------------------------
    // Framer prediction and beat checking
    // ------------------------------------------------------------------
    class framer_scoreboard;
        byte_t   sync_high;
        byte_t   sync_low;
        byte_t   max_length;

        byte_t   hunt_older;
        byte_t   hunt_newer;
        bit      in_frame;
        byte_t   remaining;
        byte_t   next_pos;
        byte_t   sum_a;
        byte_t   sum_b;
        bit      zero_opcode;

        result_t expected_beats[$];
        int      mismatches;
        int      frames_ok;
        int      frames_bad_sum;
        int      frames_zero_opcode;
        int      beats_seen;

        function new();
            sync_high  = '0;
            sync_low   = '0;
            max_length = 8'd255;
            restart_hunt();
        endfunction

        function void restart_hunt();
            in_frame    = 1'b0;
            hunt_older  = '0;
            hunt_newer  = '0;
            remaining   = '0;
            next_pos    = '0;
            sum_a       = '0;
            sum_b       = '0;
            zero_opcode = 1'b0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, byte_t value);
            case (idx)
                CFG_SYNC_HIGH:  sync_high  = value;
                CFG_SYNC_LOW:   sync_low   = value;
                CFG_MAX_LENGTH: max_length = value;
                default: ;
            endcase
        endfunction

        // One accepted rx beat: advance the framer, queue a payload beat if any.
        function void note_rx_byte(byte_t b);
            int      a;
            int      c;
            result_t beat;
            if (!in_frame) begin
                if (hunt_older == sync_high && hunt_newer == sync_low &&
                    b != 8'd0 && b <= max_length) begin
                    restart_hunt();
                    in_frame  = 1'b1;
                    remaining = b;
                end else begin
                    hunt_older = hunt_newer;
                    hunt_newer = b;
                end
                return;
            end
            a = (int'(sum_a) + int'(b)) % int'(FLETCHER_MOD);
            c = (int'(sum_b) + a) % int'(FLETCHER_MOD);
            sum_a = byte_t'(a);
            sum_b = byte_t'(c);
            if (next_pos == 8'd0)
                zero_opcode = (b == 8'd0);
            beat.payload_byte = b;
            beat.byte_pos     = next_pos;
            beat.last         = (remaining <= 8'd1);
            if (!beat.last)
                beat.status = STATUS_NOT_LAST;
            else if (zero_opcode)
                beat.status = STATUS_ZERO_OPCODE;
            else if (a != 0 || c != 0)
                beat.status = STATUS_BAD_SUM;
            else
                beat.status = STATUS_OK;
            expected_beats.push_back(beat);
            if (beat.last) begin
                restart_hunt();
            end else begin
                remaining = remaining - 8'd1;
                next_pos  = next_pos + 8'd1;
            end
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 40)
                $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_tx_beat(result_t got);
            result_t want;
            beats_seen++;
            if (expected_beats.size() == 0) begin
                report($sformatf("unexpected beat byte %02h pos %0d last %0b status %0d",
                                 got.payload_byte, got.byte_pos, got.last, got.status));
                return;
            end
            want = expected_beats.pop_front();
            if (got.payload_byte !== want.payload_byte)
                report($sformatf("payload_byte %02h, want %02h",
                                 got.payload_byte, want.payload_byte));
            if (got.byte_pos !== want.byte_pos)
                report($sformatf("byte_pos %0d, want %0d", got.byte_pos, want.byte_pos));
            if (got.last !== want.last)
                report($sformatf("last %0b, want %0b at pos %0d",
                                 got.last, want.last, want.byte_pos));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d at pos %0d",
                                 got.status, want.status, want.byte_pos));
            if (want.last) begin
                case (want.status)
                    STATUS_OK:          frames_ok++;
                    STATUS_BAD_SUM:     frames_bad_sum++;
                    STATUS_ZERO_OPCODE: frames_zero_opcode++;
                    default: ;
                endcase
            end
        endtask

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------
    logic clk;
    logic rst_n;

    shpr_in_if  rx_ch();
    shpr_out_if tx_ch();
    shpr_cfg_if cfg_ch();

    sync_header_packet_receiver DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    framer_scoreboard sb;

    // Idle percentages of the current phase, and the settings in force, as
    // the stimulus side sees them.
    int    send_idle_pct;
    int    stall_pct;
    byte_t sync_high_now;
    byte_t sync_low_now;
    byte_t max_length_now;
    int    bytes_sent;
    int    settings_used;
    int    quiet_cycles;

    // ------------------------------------------------------------------
    // Monitor: every channel is sampled at the edge, before the NBA updates
    // of that edge land. The rx beat is predicted before the tx beat of the
    // same edge is checked, so a purely combinational path would still line up.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t beat;
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_register(cfg_ch.index, cfg_ch.data);
            if (rx_ch.valid && rx_ch.ready)
                sb.note_rx_byte(rx_ch.rx_byte);
            if (tx_ch.valid && tx_ch.ready) begin
                beat.payload_byte = tx_ch.payload_byte;
                beat.byte_pos     = tx_ch.byte_pos;
                beat.last         = tx_ch.last;
                beat.status       = tx_ch.status;
                sb.check_tx_beat(beat);
            end

            // watchdog: any beat on any channel counts as progress
            if ((cfg_ch.valid && cfg_ch.ready) || (rx_ch.valid && rx_ch.ready) ||
                (tx_ch.valid && tx_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] no beat for %0d cycles, %0d beats still expected",
                         $realtime, QUIET_LIMIT, sb.pending());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Receiver side: ready is redrawn every cycle from the phase's stall rate.
    initial
    begin
        tx_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            tx_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One rx beat, preceded by random idle cycles. valid stays high into the
    // next beat when no idle is drawn.
    task automatic send_byte(input byte_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (!rx_ch.ready);
        bytes_sent++;
    endtask

    // Sender holds off until every predicted beat is out, then lets the last
    // header bytes settle.
    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input byte_t value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input byte_t sh, input byte_t sl, input byte_t ml);
        wait_drained();
        write_reg(CFG_SYNC_HIGH, sh);
        write_reg(CFG_SYNC_LOW, sl);
        write_reg(CFG_MAX_LENGTH, ml);
        sync_high_now  = sh;
        sync_low_now   = sl;
        max_length_now = ml;
        settings_used++;
    endtask

    // Header plus payload. A good frame gets its last two bytes solved so both
    // Fletcher sums close at zero; a zero residue is sent as 0 or 255 at random
    // (255 is 0 mod 255), and as 255 in the opcode slot to keep the opcode live.
    task automatic send_frame(input int length, input frame_kind_t kind);
        byte_t body[255];
        int    a;
        int    c;
        int    x;
        int    y;
        int    i;
        a = 0;
        c = 0;
        for (i = 0; i < length; i++)
            body[i] = byte_t'($urandom_range(255));
        if (kind == FRAME_ZERO_OPCODE)
            body[0] = 8'd0;
        if (kind == FRAME_GOOD) begin
            if (length == 1) begin
                body[0] = 8'hFF;
            end else begin
                for (i = 0; i < length - 2; i++) begin
                    a = (a + body[i]) % 255;
                    c = (c + a) % 255;
                end
                x = (510 - a - c) % 255;
                y = c;
                if (x == 0 && (length == 2 || $urandom_range(1) == 1))
                    x = 255;
                if (y == 0 && $urandom_range(1) == 1)
                    y = 255;
                body[length-2] = byte_t'(x);
                body[length-1] = byte_t'(y);
            end
        end
        send_byte(sync_high_now);
        send_byte(sync_low_now);
        send_byte(byte_t'(length));
        for (i = 0; i < length; i++)
            send_byte(body[i]);
    endtask

    // Mostly well-formed frames with random content; the rest is line noise
    // and headers that must be refused (zero length, length over the limit,
    // wrong second ID byte). Small lengths dominate, a few run up to 32.
    task automatic random_traffic(input int budget);
        int start;
        int roll;
        int limit;
        int cap;
        int len;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            roll  = $urandom_range(99);
            limit = (max_length_now == 8'd0) ? 8 : int'(max_length_now);
            cap   = (limit < 8) ? limit : 8;
            if ($urandom_range(7) == 0)
                cap = (limit < 32) ? limit : 32;
            len = $urandom_range(1, cap);

            if ($urandom_range(99) < 30)
                repeat ($urandom_range(1, 3)) send_byte(byte_t'($urandom_range(255)));

            if (roll >= 88) begin
                send_byte(sync_high_now);
                case ($urandom_range(2))
                    0: begin
                        send_byte(sync_low_now);
                        send_byte(8'd0);
                    end
                    1: begin
                        send_byte(sync_low_now);
                        if (max_length_now == 8'd255)
                            send_byte(8'd0);
                        else
                            send_byte(byte_t'($urandom_range(255, max_length_now + 1)));
                    end
                    default: begin
                        send_byte(~sync_low_now);
                        send_byte(byte_t'($urandom_range(1, 255)));
                    end
                endcase
            end else if (roll < 58) begin
                send_frame(len, FRAME_GOOD);
            end else if (roll < 76) begin
                send_frame(len, FRAME_NOISY_SUM);
            end else begin
                send_frame(len, FRAME_ZERO_OPCODE);
            end

            // occasional full hold-off so the output side runs dry mid-phase
            if ($urandom_range(39) == 0)
                wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= CFG_SYNC_HIGH;
        cfg_ch.data   <= '0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        sync_high_now  = '0;
        sync_low_now   = '0;
        max_length_now = 8'd255;
        bytes_sent     = 0;
        settings_used  = 1;
        quiet_cycles   = 0;
        sb = new();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, at reset settings: both ID bytes are zero, so the cleared
        // window already matches and a bare length byte opens a frame.
        send_byte(8'd1);            // single byte 255: sums close, opcode nonzero
        send_byte(8'hFF);
        send_byte(8'd1);            // single byte 0: zero opcode with clean sums
        send_byte(8'd0);
        send_byte(8'd0);            // zero length is no header
        send_frame(3, FRAME_GOOD);
        send_frame(2, FRAME_GOOD);  // opcode forced to 255
        send_byte(8'd3);            // zero opcode wins over a bad sum
        send_byte(8'd0);
        send_byte(8'd1);
        send_byte(8'd2);
        send_byte(8'd2);            // first sum closes, second does not
        send_byte(8'h80);
        send_byte(8'h7F);
        random_traffic(15);

        // Fixed ID pair, full limit, one frame of the longest length.
        configure(8'hA5, 8'h5A, 8'd255);
        send_frame(255, FRAME_GOOD);
        random_traffic(15);

        // All-ones IDs, limit of one; sender mostly idle.
        send_idle_pct = 79;
        configure(8'hFF, 8'hFF, 8'd1);
        random_traffic(15);

        // Random IDs and limit; receiver mostly stalled.
        send_idle_pct = 0;
        stall_pct     = 79;
        configure(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
                  byte_t'($urandom_range(2, 40)));
        random_traffic(15);

        // Limit of zero: headers never match, the framer hunts throughout.
        send_idle_pct = 19;
        stall_pct     = 19;
        configure(8'h12, 8'h34, 8'd0);
        random_traffic(10);

        // Zero IDs again with a small limit: frames start right after frames.
        configure(8'h00, 8'h00, 8'd8);
        random_traffic(15);

        // Back to a clean line at a mid-range setting.
        send_idle_pct = 0;
        stall_pct     = 0;
        configure(8'h00, 8'hFF, 8'd20);
        random_traffic(15);

        wait_drained();

        $display("%0d rx beats over %0d register settings, %0d payload beats checked",
                 bytes_sent, settings_used, sb.beats_seen);
        $display("frames closed: %0d ok, %0d bad checksum, %0d zero opcode",
                 sb.frames_ok, sb.frames_bad_sum, sb.frames_zero_opcode);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
sv/shpr_pkg.sv
sv/shpr_if.sv
sv/shpr_fletcher.sv
sv/sync_header_packet_receiver.sv
verif/testbench.sv
